### design/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### design/becm_pkg.sv
// constants and codes for the big-endian checked memory
// no dependencies
`timescale 1ns / 1ps

package becm_pkg;

  localparam int MEM_BYTES  = 65536;
  localparam int NUM_BANKS  = 8;
  localparam int LANE_W     = $clog2(NUM_BANKS);
  localparam int BANK_DEPTH = MEM_BYTES / NUM_BANKS;
  localparam int ROW_W      = $clog2(BANK_DEPTH);

  localparam int ADDR_W     = 32;
  localparam int DATA_W     = 64;
  localparam int SIZE_W     = 2;
  localparam int MSIZE_W    = 17;
  localparam int END_W      = ADDR_W + 1;

  localparam logic [MSIZE_W-1:0] MSIZE_RESET = MSIZE_W'(65536);
  localparam logic [END_W-1:0]   MEM_LIMIT   = END_W'(MEM_BYTES);

  // apb register map
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam logic REG_MEMORY_SIZE = 1'b0;

  // access codes
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

endpackage

### design/big_endian_checked_memory.sv
// big-endian byte-addressed memory with range check, top level
// depends on becm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Byte-addressed memory of becm_pkg::MEM_BYTES bytes held in eight byte-wide
// banks, so any 1, 2, 4 or 8 byte access, aligned or not, is served in one
// memory pass; the byte at the given address is the most significant byte of
// the value. An access whose address plus width passes the memory_size register
// (register 0, APB offset 0) or the store reports range_error, reads zero and
// writes nothing. After reset the block clears the banks one row per cycle,
// with in_ready low; configuration writes are taken meanwhile. After that one
// word is accepted per cycle: the bank read sits in the accept cycle, the
// result moves from the read stage into the output register once that is free,
// and a waiting result stalls input only once a second word is behind it.
module big_endian_checked_memory (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [becm_pkg::SIZE_W-1:0]    in_size_code,
  input  logic [becm_pkg::ADDR_W-1:0]    in_address,
  input  logic [becm_pkg::DATA_W-1:0]    in_write_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [becm_pkg::DATA_W-1:0]    out_read_data,
  output logic                           out_range_error,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [becm_pkg::PADDR_W-1:0]   paddr,
  input  logic [becm_pkg::PDATA_W-1:0]   pwdata,
  output logic [becm_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import becm_pkg::*;

  // configuration
  logic [MSIZE_W-1:0] msize_r;
  logic               cfg_wr;

  // clearing pass
  logic             clr_busy_r, clr_busy_nxt;
  logic [ROW_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // access decode
  logic              in_fire;
  logic [3:0]        in_width;
  logic [END_W-1:0]  in_end;
  logic [END_W-1:0]  limit;
  logic              in_range;
  logic [LANE_W-1:0] in_lo;
  logic [ROW_W-1:0]  in_row;

  // bank ports
  logic             bank_we [NUM_BANKS];
  logic             bank_re;
  logic [ROW_W-1:0] bank_addr [NUM_BANKS];
  logic [7:0]       bank_wdata [NUM_BANKS];
  logic [7:0]       rd_q_r [NUM_BANKS];

  // read stage
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_move;
  logic              s1_read_r;
  logic              s1_err_r;
  logic [LANE_W-1:0] s1_lo_r;
  logic [SIZE_W-1:0] s1_size_r;
  logic [3:0]        s1_width;
  logic [7:0]        s1_byte [NUM_BANKS];
  logic [DATA_W-1:0] s1_data;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_read_data_r;
  logic              out_range_error_r;

  // ---------------------------------------------------------------------------
  // apb register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_MEMORY_SIZE);
  assign prdata = (paddr[2] == REG_MEMORY_SIZE) ? PDATA_W'(msize_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msize_r <= MSIZE_RESET;
    end else if (cfg_wr) begin
      msize_r <= pwdata[MSIZE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // clearing pass after reset
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + ROW_W'(1);
      if (clr_cnt_r == {ROW_W{1'b1}}) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // accept and range check
  assign s1_move  = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~clr_busy_r & (~s1_valid_r | s1_move);
  assign in_fire  = in_valid & in_ready;

  assign in_width = 4'd1 << in_size_code;
  assign in_end   = {1'b0, in_address} + END_W'(in_width);
  assign limit    = ({{(END_W-MSIZE_W){1'b0}}, msize_r} > MEM_LIMIT) ?
                    MEM_LIMIT : {{(END_W-MSIZE_W){1'b0}}, msize_r};
  assign in_range = (in_end <= limit);
  assign in_lo    = in_address[LANE_W-1:0];
  assign in_row   = in_address[ROW_W+LANE_W-1:LANE_W];
  assign bank_re  = in_fire & (in_action == ACT_READ) & in_range;

  // ---------------------------------------------------------------------------
  // byte banks
  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    logic [7:0]        mem [BANK_DEPTH];
    logic [LANE_W-1:0] off;
    logic [LANE_W-1:0] pos;
    logic              active;
    logic [ROW_W-1:0]  row;

    // offset of this bank's byte within the access, and its place in the value
    assign off    = LANE_W'(g) - in_lo;
    assign active = ({1'b0, off} < in_width);
    assign pos    = LANE_W'(in_width - 4'd1) - off;
    // banks below the start lane hold bytes of the next row
    assign row    = in_row + ROW_W'(LANE_W'(g) < in_lo);

    assign bank_we[g]    = clr_busy_r |
                           (in_fire & (in_action == ACT_WRITE) & in_range & active);
    assign bank_addr[g]  = clr_busy_r ? clr_cnt_r : row;
    assign bank_wdata[g] = clr_busy_r ? 8'h00 : in_write_data[{pos, 3'b000} +: 8];

    always_ff @(posedge clk) begin
      if (bank_we[g]) begin
        mem[bank_addr[g]] <= bank_wdata[g];
      end
    end

    // read data holds until the next read, so a stalled word keeps it
    always_ff @(posedge clk) begin
      if (bank_re) begin
        rd_q_r[g] <= mem[bank_addr[g]];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // read stage: rotate bank bytes into big-endian order
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_read_r <= (in_action == ACT_READ);
      s1_err_r  <= ~in_range;
      s1_lo_r   <= in_lo;
      s1_size_r <= in_size_code;
    end
  end

  assign s1_width = 4'd1 << s1_size_r;

  for (genvar k = 0; k < NUM_BANKS; k++) begin : g_lane
    logic [LANE_W-1:0] idx;
    logic [LANE_W-1:0] bank;

    // value byte k comes from access byte width-1-k
    assign idx        = LANE_W'(s1_width - 4'd1) - LANE_W'(k);
    assign bank       = s1_lo_r + idx;
    assign s1_byte[k] = (4'(k) < s1_width) ? rd_q_r[bank] : 8'h00;
    assign s1_data[8*k +: 8] = s1_byte[k];
  end

  // ---------------------------------------------------------------------------
  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_read_data_r   <= (s1_read_r & ~s1_err_r) ? s1_data : '0;
      out_range_error_r <= s1_err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_read_data_r;
  assign out_range_error = out_range_error_r;

  // ---------------------------------------------------------------------------
  // assertions
  `ASSERT_IMP(a_no_work_while_clearing, clk, rst_n, clr_busy_r, !s1_valid_r && !out_valid_r)
  `ASSERT_NXT(a_accept_fills_stage, clk, rst_n, in_fire, s1_valid_r)
  `ASSERT_NXT(a_stalled_stage_holds, clk, rst_n, s1_valid_r && !s1_move,
              s1_valid_r && $stable(s1_lo_r) && $stable(s1_size_r) && $stable(s1_err_r))
  `ASSERT_IMP(a_error_reads_zero, clk, rst_n, out_valid_r && out_range_error_r,
              out_read_data_r == '0)

endmodule

### bench/tb_top.sv
// self-checking bench for the big-endian checked memory: mirror of the byte store,
// randomized bursts on the input channel, stalls on the result channel
// depends on becm_pkg and big_endian_checked_memory
`timescale 1ns / 1ps

module tb_top;
  import becm_pkg::*;

  localparam int LIMIT = 200000;

  localparam logic [SIZE_W-1:0] SZ_BYTE  = 2'd0;
  localparam logic [SIZE_W-1:0] SZ_HALF  = 2'd1;
  localparam logic [SIZE_W-1:0] SZ_WORD  = 2'd2;
  localparam logic [SIZE_W-1:0] SZ_DWORD = 2'd3;

  localparam logic [PADDR_W-1:0] MSIZE_ADDR = {REG_MEMORY_SIZE, 2'b00};

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE, RX_PULSE} rx_mode_t;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic              range_error;
  } reply_t;

  // mirror of the memory contents plus the queue of replies still owed
  class be_mem_mirror;
    bit [7:0]           store [MEM_BYTES];
    logic [MSIZE_W-1:0] size_cfg;
    reply_t             replies_due[$];
    int                 faults;
    int                 reads;
    int                 writes;
    int                 range_errs;

    function new();
      size_cfg   = MSIZE_RESET;
      faults     = 0;
      reads      = 0;
      writes     = 0;
      range_errs = 0;
    endfunction

    function void flag(string msg);
      faults++;
      if (faults <= 10) $display("mismatch: %s", msg);
    endfunction

    function void note_access(logic act, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] wd);
      reply_t      r;
      int          width;
      bit [63:0]   end_addr;
      int unsigned lim;
      width    = 1 << sz;
      end_addr = {32'b0, addr} + 64'(width);
      lim      = (size_cfg > MEM_BYTES) ? MEM_BYTES : size_cfg;
      r.read_data   = '0;
      r.range_error = 1'b0;
      if (act == ACT_READ) reads++;
      else writes++;
      if (end_addr > 64'(lim)) begin
        r.range_error = 1'b1;
        range_errs++;
      end else if (act == ACT_READ) begin
        for (int i = 0; i < width; i++)
          r.read_data = {r.read_data[DATA_W-9:0], store[int'(addr) + i]};
      end else begin
        // first byte at the address is the most significant one
        for (int i = 0; i < width; i++)
          store[int'(addr) + i] = 8'(wd >> ((width - 1 - i) * 8));
      end
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [DATA_W-1:0] rd, logic err);
      reply_t want;
      if (replies_due.size() == 0) begin
        flag($sformatf("word with nothing pending: read_data %h range_error %b", rd, err));
        return;
      end
      want = replies_due.pop_front();
      if (rd !== want.read_data || err !== want.range_error)
        flag($sformatf("read_data %h range_error %b, expected %h / %b",
                       rd, err, want.read_data, want.range_error));
    endfunction
  endclass

  logic                clk;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_ready;
  logic                in_action       = 1'b0;
  logic [SIZE_W-1:0]   in_size_code    = '0;
  logic [ADDR_W-1:0]   in_address      = '0;
  logic [DATA_W-1:0]   in_write_data   = '0;
  logic                out_valid;
  logic                out_ready       = 1'b0;
  logic [DATA_W-1:0]   out_read_data;
  logic                out_range_error;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [PADDR_W-1:0]  paddr           = '0;
  logic [PDATA_W-1:0]  pwdata          = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  be_mem_mirror sb = new();

  int       cycles      = 0;
  int       burst_left  = 0;
  int       idle_gap    = 0;
  bit       stream_on   = 0;
  int       settings    = 0;
  rx_mode_t rx_mode     = RX_OPEN;
  int       rx_left     = 0;

  big_endian_checked_memory u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_size_code    (in_size_code),
    .in_address      (in_address),
    .in_write_data   (in_write_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_range_error (out_range_error),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("big_endian_checked_memory regression: fail");
      $finish;
    end
  end

  // result side stalls follow a randomly chosen mode, redrawn whenever its run ends
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_COIN:  out_ready <= ($urandom_range(0, 1) == 1);
      RX_CHOKE: out_ready <= ($urandom_range(0, 3) == 0);
      default:  out_ready <= cycles[2];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_reply(out_read_data, out_range_error);
  end

  task automatic send_word(input logic act, input logic [SIZE_W-1:0] sz,
                           input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] wd);
    if (idle_gap > 0) begin
      repeat (idle_gap) @(posedge clk);
      idle_gap = 0;
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_size_code  <= sz;
    in_address    <= addr;
    in_write_data <= wd;
    stream_on = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_access(act, sz, addr, wd);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      stream_on = 0;
      idle_gap   = $urandom_range(1, 7);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // called in the step of the last accept so the held word is not taken twice
  task automatic stop_stream();
    if (stream_on) begin
      in_valid <= 1'b0;
      stream_on = 0;
    end
  endtask

  task automatic wait_drained();
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_memory_size(input int unsigned sz);
    logic [PDATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MSIZE_ADDR;
    pwdata  <= PDATA_W'(sz);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.size_cfg = MSIZE_W'(sz);
    settings++;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    // read back what was just written
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== PDATA_W'(sb.size_cfg))
      sb.flag($sformatf("memory_size reads %h, expected %h", got, sb.size_cfg));
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned lim;
    int unsigned pick;
    lim  = (sb.size_cfg > MEM_BYTES) ? MEM_BYTES : sb.size_cfg;
    pick = $urandom_range(0, 99);
    // small hot region so reads land on earlier writes, plus edges of the range
    if (pick < 45) return $urandom_range(0, 47);
    if (pick < 65) return (lim > 12) ? $urandom_range(lim - 12, lim + 4) : $urandom_range(0, lim + 4);
    if (pick < 75) return $urandom_range(MEM_BYTES - 12, MEM_BYTES + 4);
    if (pick < 88) return $urandom_range(0, MEM_BYTES - 1);
    if (pick < 94) return 32'hFFFF_FFFF - $urandom_range(0, 9);
    return $urandom();
  endfunction

  task automatic run_random(input int n);
    logic [DATA_W-1:0] wd;
    int                pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 9);
      wd   = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom(), $urandom()};
      send_word(logic'($urandom_range(0, 1)), SIZE_W'($urandom_range(0, 3)), pick_address(), wd);
    end
    stop_stream();
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // writes are taken while the store is still being cleared
    program_memory_size(65536);

    send_word(ACT_READ,  SZ_DWORD, 32'd0,         64'h0);
    send_word(ACT_WRITE, SZ_DWORD, 32'd0,         64'h0102_0304_0506_0708);
    send_word(ACT_READ,  SZ_BYTE,  32'd0,         64'h0);
    send_word(ACT_READ,  SZ_HALF,  32'd1,         64'h0);
    send_word(ACT_READ,  SZ_WORD,  32'd3,         64'h0);
    send_word(ACT_READ,  SZ_DWORD, 32'd0,         64'h0);
    send_word(ACT_WRITE, SZ_BYTE,  32'd5,         64'hFFFF_FFFF_FFFF_FFAB);
    send_word(ACT_READ,  SZ_DWORD, 32'd0,         64'h0);
    send_word(ACT_WRITE, SZ_HALF,  32'd7,         64'hDEAD_BEEF_0000_C0DE);
    send_word(ACT_READ,  SZ_DWORD, 32'd4,         64'h0);
    send_word(ACT_WRITE, SZ_DWORD, 32'd65528,     64'hFFFF_FFFF_FFFF_FFFF);
    send_word(ACT_READ,  SZ_DWORD, 32'd65528,     64'h0);
    send_word(ACT_READ,  SZ_DWORD, 32'd65529,     64'h0);
    send_word(ACT_WRITE, SZ_WORD,  32'd65533,     64'h1122_3344_5566_7788);
    send_word(ACT_READ,  SZ_BYTE,  32'd65535,     64'h0);
    send_word(ACT_WRITE, SZ_BYTE,  32'd65536,     64'h5A);
    send_word(ACT_READ,  SZ_DWORD, 32'hFFFF_FFFF, 64'h0);
    send_word(ACT_WRITE, SZ_DWORD, 32'hFFFF_FFF8, 64'hA5A5_A5A5_A5A5_A5A5);
    send_word(ACT_WRITE, SZ_WORD,  32'h8000_0000, 64'hFFFF_FFFF);
    send_word(ACT_READ,  SZ_WORD,  32'd65532,     64'h0);
    send_word(ACT_WRITE, SZ_DWORD, 32'd3,         64'h8000_0000_0000_0001);
    send_word(ACT_READ,  SZ_DWORD, 32'd3,         64'h0);
    run_random(120);

    program_memory_size(4096);
    run_random(70);
    program_memory_size(0);
    run_random(20);
    program_memory_size(131071);
    run_random(70);
    program_memory_size(1);
    run_random(20);
    program_memory_size($urandom_range(8, 65535));
    run_random(60);
    program_memory_size(65535);
    run_random(40);

    repeat (8) @(posedge clk);
    if (sb.replies_due.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.replies_due.size()));
    $display("covered %0d reads and %0d writes over %0d memory_size settings",
             sb.reads, sb.writes, settings);
    $display("%0d accesses hit the range check, %0d faults seen", sb.range_errs, sb.faults);
    if (sb.faults == 0) begin
      $display("big_endian_checked_memory regression: pass");
    end else begin
      $display("big_endian_checked_memory regression: fail");
    end
    $finish;
  end

endmodule
